// ===== sv/grmd_pkg.sv =====
// grmd_pkg: shared constants, types and the quarter-wave sine table
// for the grid ray march block; no dependencies
package grmd_pkg;

    // map geometry and fixed point formats
    localparam int MAP_COLS   = 64;
    localparam int MAP_ROWS   = 64;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 6;
    localparam int MAP_AW     = COL_W + ROW_W;
    localparam int MAP_DEPTH  = MAP_COLS * MAP_ROWS;
    localparam int FRAC_BITS  = 16;
    localparam int EXT_BITS   = FRAC_BITS + 16;

    // angles in sixteenths of a degree
    localparam int ANG_W      = 13;
    localparam logic [ANG_W-1:0] FULL_TURN    = 13'd5760;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 13'd1440;

    // datapath widths
    localparam int TRIG_W     = 17;
    localparam int POS_W      = 48;
    localparam int DIVD_W     = 33;
    localparam int RATE_W     = 8;
    localparam int REACH_W    = 6;
    localparam int STEP_W     = 14;
    localparam int DIST_W     = 22;
    localparam int PROD_W     = 30 + TRIG_W;
    localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAYER_X    = 3'd0,
        CFG_PLAYER_Y    = 3'd1,
        CFG_VIEW_ANGLE  = 3'd2,
        CFG_MARCH_RATE  = 3'd3,
        CFG_REACH_LIMIT = 3'd4
    } cfg_index_t;

    // trig unit request and result
    typedef struct packed {
        logic             valid;
        logic [ANG_W-1:0] angle;
        logic             use_cos;
    } trig_req_t;

    typedef struct packed {
        logic              valid;
        logic [TRIG_W-1:0] mag;
        logic              neg;
    } trig_res_t;

    // Q16 sine sampled every 5.625 degrees over one quadrant
    function automatic logic [TRIG_W-1:0] quarter_sine(input logic [4:0] idx);
        logic [TRIG_W-1:0] v;
        case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd6424;
            5'd2:    v = 17'd12785;
            5'd3:    v = 17'd19024;
            5'd4:    v = 17'd25080;
            5'd5:    v = 17'd30893;
            5'd6:    v = 17'd36410;
            5'd7:    v = 17'd41576;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd50660;
            5'd10:   v = 17'd54491;
            5'd11:   v = 17'd57798;
            5'd12:   v = 17'd60547;
            5'd13:   v = 17'd62714;
            5'd14:   v = 17'd64277;
            5'd15:   v = 17'd65220;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/grid_ray_march_distance.sv =====
// grid_ray_march_distance: fixed-step ray march over a one-bit grid map
// depends on grmd_pkg, grmd_ram, grmd_trig, grmd_div
//
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tuser=operation, tdata=row,col,blocks,angle
// m_*       out  tvalid/tready      tdata=distance, tuser=hit
// cfg_*     in   cfg_we             cfg_index, cfg_data
//
// a map write is made as the request is accepted; a cast marches up to
// reach_limit*march_rate steps (a zero rate counts as one), with one map read
// per step (single ram port), after the trig pipeline and two step divides,
// and ends with one distance divide, all divides in the shared serial divider.
// after reset a clearing pass writes all 4096 cells, with s_tready low.
// a finished result waits in the output register; the next request is taken.
module grid_ray_march_distance (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // cell_row, cell_col, cell_blocks, angle
    input  logic                           s_tuser,  // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,  // distance
    output logic                           m_tuser,  // hit
    input  logic                           cfg_we,
    input  logic [grmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [grmd_pkg::CFG_W-1:0]     cfg_data
);
    import grmd_pkg::*;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_TRIG   = 10'b0000000100,
        ST_DIV_X  = 10'b0000001000,
        ST_DIV_Y  = 10'b0000010000,
        ST_MSTART = 10'b0000100000,
        ST_MARCH  = 10'b0001000000,
        ST_DIST   = 10'b0010000000,
        ST_EMIT   = 10'b0100000000,
        ST_SPARE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [DIST_W-1:0]  player_x_reg, player_y_reg;
    logic [ANG_W-1:0]   view_angle_reg;
    logic [RATE_W-1:0]  march_rate_reg;
    logic [REACH_W-1:0] reach_limit_reg;

    // request fields
    logic               operation;
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_col;
    logic               cell_blocks;
    logic [ANG_W-1:0]   cast_angle;
    logic               in_accept;

    // cast context
    logic [ANG_W-1:0]   ray_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [STEP_W-1:0]  limit_reg;
    logic [STEP_W-1:0]  steps_reg;
    logic [1:0]         iss_reg, rcv_reg;
    logic [TRIG_W-1:0]  cos_mag_reg, sin_mag_reg, corr_mag_reg;
    logic               cos_neg_reg, sin_neg_reg, corr_neg_reg;
    logic signed [POS_W-1:0] px_reg, py_reg, dx_reg, dy_reg;
    logic signed [POS_W-1:0] px_adv, py_adv, step_val;
    logic               oob_reg;
    logic               hit_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [MAP_AW-1:0]  clr_reg;

    // output register
    logic               m_valid_reg;
    logic [DIST_W-1:0]  m_dist_reg;
    logic               m_hit_reg;

    logic [ANG_W-1:0]   ray_mod, view_mod, diff_ang;
    logic [RATE_W-1:0]  rate_eff;
    logic [DIST_W+15:0] start_x, start_y;

    trig_req_t          trig_req;
    trig_res_t          trig_res;

    logic               div_start, div_busy, div_done;
    logic [DIVD_W-1:0]  div_dividend, div_quot;

    logic               ram_we, ram_wdata, ram_rdata;
    logic [MAP_AW-1:0]  ram_addr;

    logic               blk, stop, emit_ok;
    logic [30:0]        dist_full;
    logic [DIST_W-1:0]  dist_sat;

    // cell of a position and whether it lies outside the map
    function automatic logic [MAP_AW-1:0] cell_addr(
        input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] y
    );
        return {y[EXT_BITS+ROW_W-1:EXT_BITS], x[EXT_BITS+COL_W-1:EXT_BITS]};
    endfunction

    function automatic logic cell_oob(
        input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] y
    );
        return (|x[POS_W-1:EXT_BITS+COL_W]) | (|y[POS_W-1:EXT_BITS+ROW_W]);
    endfunction

    // request decode
    assign operation   = s_tuser;
    assign cell_row    = s_tdata[5:0];
    assign cell_col    = s_tdata[11:6];
    assign cell_blocks = s_tdata[12];
    assign cast_angle  = s_tdata[25:13];
    assign s_tready    = (state_reg == ST_IDLE);
    assign in_accept   = s_tvalid & s_tready;

    // angle reduction, rate guard and start position
    always_comb
    begin
        ray_mod  = (cast_angle >= FULL_TURN) ? 13'(cast_angle - FULL_TURN) : cast_angle;
        view_mod = (view_angle_reg >= FULL_TURN) ? 13'(view_angle_reg - FULL_TURN)
                                                  : view_angle_reg;
        diff_ang = (ray_reg >= view_mod) ? 13'(ray_reg - view_mod)
                                         : 13'(ray_reg + FULL_TURN - view_mod);
        rate_eff = (march_rate_reg == '0) ? 8'd1 : march_rate_reg;
        start_x  = {player_x_reg, 16'd0};
        start_y  = {player_y_reg, 16'd0};
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg    <= '0;
            player_y_reg    <= '0;
            view_angle_reg  <= '0;
            march_rate_reg  <= 8'd50;
            reach_limit_reg <= 6'd11;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PLAYER_X:    player_x_reg    <= cfg_data;
                CFG_PLAYER_Y:    player_y_reg    <= cfg_data;
                CFG_VIEW_ANGLE:  view_angle_reg  <= cfg_data[ANG_W-1:0];
                CFG_MARCH_RATE:  march_rate_reg  <= cfg_data[RATE_W-1:0];
                CFG_REACH_LIMIT: reach_limit_reg <= cfg_data[REACH_W-1:0];
                default: ;
            endcase
        end
    end

    // trig requests: cos of ray, sin of ray, cos of ray minus view
    always_comb
    begin
        trig_req.valid   = (state_reg == ST_TRIG) && (iss_reg != 2'd3);
        trig_req.use_cos = (iss_reg != 2'd1);
        trig_req.angle   = (iss_reg == 2'd2) ? diff_ang : ray_reg;
    end

    grmd_trig u_trig (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (trig_req),
        .res   (trig_res)
    );

    // march advance
    assign px_adv = px_reg + dx_reg;
    assign py_adv = py_reg + dy_reg;
    assign blk    = oob_reg | ram_rdata;
    assign stop   = blk || (steps_reg >= limit_reg);
    assign step_val = POS_W'(signed'({1'b0, div_quot}));

    // map port: clear sweep, cell write, march reads
    always_comb
    begin
        ram_we    = (state_reg == ST_CLEAR) | (in_accept & ~operation);
        ram_wdata = (state_reg == ST_CLEAR) ? 1'b0 : cell_blocks;
        if (state_reg == ST_CLEAR)
        begin
            ram_addr = clr_reg;
        end
        else if (state_reg == ST_IDLE)
        begin
            ram_addr = {cell_row, cell_col};
        end
        else if (state_reg == ST_MARCH)
        begin
            ram_addr = cell_addr(px_adv, py_adv);
        end
        else
        begin
            ram_addr = cell_addr(px_reg, py_reg);
        end
    end

    grmd_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // output register may take a new result when empty or draining
    assign emit_ok = !m_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == MAP_AW'(MAP_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept && operation)
                begin
                    state_next = ST_TRIG;
                end
            end
            ST_TRIG:
            begin
                if (trig_res.valid && rcv_reg == 2'd2)
                begin
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_done)
                begin
                    state_next = ST_MSTART;
                end
            end
            ST_MSTART:
            begin
                state_next = ST_MARCH;
            end
            ST_MARCH:
            begin
                if (stop)
                begin
                    state_next = ST_DIST;
                end
            end
            ST_DIST:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // divider launch on entry to a divide state
    always_comb
    begin
        div_start = (state_next != state_reg) &&
                    ((state_next == ST_DIV_X) || (state_next == ST_DIV_Y) ||
                     (state_next == ST_DIST));
        if (state_next == ST_DIV_X)
        begin
            div_dividend = {cos_mag_reg, 16'd0};
        end
        else if (state_next == ST_DIV_Y)
        begin
            div_dividend = {sin_mag_reg, 16'd0};
        end
        else
        begin
            div_dividend = {3'd0, steps_reg, 16'd0};
        end
    end

    grmd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (rate_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // corrected distance with saturation
    always_comb
    begin
        dist_full = prod_reg[PROD_W-1:16];
        if (corr_neg_reg)
        begin
            dist_sat = '0;
        end
        else if (|dist_full[30:DIST_W])
        begin
            dist_sat = DIST_MAX;
        end
        else
        begin
            dist_sat = dist_full[DIST_W-1:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            iss_reg     <= '0;
            rcv_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= MAP_AW'(clr_reg + 1'b1);
            end
            if (in_accept)
            begin
                iss_reg <= '0;
                rcv_reg <= '0;
            end
            else
            begin
                if (trig_req.valid)
                begin
                    iss_reg <= 2'(iss_reg + 2'd1);
                end
                if (trig_res.valid)
                begin
                    rcv_reg <= 2'(rcv_reg + 2'd1);
                end
            end
            if (state_reg == ST_EMIT && emit_ok)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // cast datapath
    always_ff @(posedge clk)
    begin
        if (in_accept && operation)
        begin
            ray_reg   <= ray_mod;
            rate_reg  <= rate_eff;
            limit_reg <= STEP_W'(reach_limit_reg * rate_eff);
            px_reg    <= POS_W'(start_x) + POS_W'(64'd1 << (EXT_BITS - 1));
            py_reg    <= POS_W'(start_y) + POS_W'(64'd1 << (EXT_BITS - 1));
        end
        if (trig_res.valid)
        begin
            case (rcv_reg)
                2'd0:
                begin
                    cos_mag_reg <= trig_res.mag;
                    cos_neg_reg <= trig_res.neg;
                end
                2'd1:
                begin
                    sin_mag_reg <= trig_res.mag;
                    sin_neg_reg <= trig_res.neg;
                end
                default:
                begin
                    corr_mag_reg <= trig_res.mag;
                    corr_neg_reg <= trig_res.neg;
                end
            endcase
        end
        if (state_reg == ST_DIV_X && div_done)
        begin
            dx_reg <= cos_neg_reg ? -step_val : step_val;
        end
        if (state_reg == ST_DIV_Y && div_done)
        begin
            dy_reg <= sin_neg_reg ? -step_val : step_val;
        end
        if (state_reg == ST_MSTART)
        begin
            steps_reg <= '0;
            oob_reg   <= cell_oob(px_reg, py_reg);
        end
        if (state_reg == ST_MARCH)
        begin
            if (stop)
            begin
                hit_reg <= blk;
            end
            else
            begin
                px_reg    <= px_adv;
                py_reg    <= py_adv;
                steps_reg <= STEP_W'(steps_reg + 1'b1);
                oob_reg   <= cell_oob(px_adv, py_adv);
            end
        end
        if (state_reg == ST_DIST && div_done)
        begin
            prod_reg <= PROD_W'(div_quot[29:0] * corr_mag_reg);
        end
        if (state_reg == ST_EMIT && emit_ok)
        begin
            m_dist_reg <= dist_sat;
            m_hit_reg  <= hit_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'd0, m_dist_reg};
    assign m_tuser  = m_hit_reg;

`ifndef SYNTHESIS
    // no request taken during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("request taken while map clears");

    // march never runs past its step bound
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MARCH |-> steps_reg <= limit_reg)
        else $error("march step count beyond limit");

    // map written only by clear sweep or cell write
    a_map_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE || state_reg == ST_CLEAR))
        else $error("map write during a cast");

    // divider is idle whenever a divide is launched
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divide launched while divider busy");

    // a finished cast always lands in the output register
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && emit_ok) |=> m_valid_reg)
        else $error("result lost at emit");
`endif

endmodule

// ===== sv/grmd_ram.sv =====
// grmd_ram: generic single-port synchronous ram with registered read
// no dependencies
module grmd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read before write port, read data registered and valid in the next cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== sv/grmd_trig.sv =====
// grmd_trig: five-stage pipelined Q16 sine/cosine with table interpolation
// depends on grmd_pkg
module grmd_trig (
    input  logic                clk,
    input  logic                rst_n,
    input  grmd_pkg::trig_req_t req,
    output grmd_pkg::trig_res_t res
);
    import grmd_pkg::*;

    logic [4:0]  vld_reg;

    // stage 0: fold angle into first quadrant
    logic [ANG_W:0]   a_ext;
    logic [ANG_W-1:0] a_w;
    logic [1:0]       quad;
    logic [ANG_W-1:0] quad_base;
    logic [10:0]      r_in;
    logic [10:0]      r_fold;

    logic [10:0] r1_reg;
    logic        neg1_reg;
    logic [10:0] r2_reg;
    logic [4:0]  idx2_reg;
    logic        neg2_reg;
    logic [19:0] p3_reg;
    logic [TRIG_W-1:0] base3_reg;
    logic        neg3_reg;
    logic [13:0] q4_reg;
    logic [19:0] p4_reg;
    logic [TRIG_W-1:0] base4_reg;
    logic        neg4_reg;
    logic [TRIG_W-1:0] mag5_reg;
    logic        neg5_reg;

    logic [24:0] idx_prod;
    logic [10:0] idx_x90;
    logic [6:0]  frac;
    logic [4:0]  nxt_idx;
    logic [TRIG_W-1:0] tab_lo;
    logic [TRIG_W-1:0] tab_hi;
    logic [12:0] delta;
    logic [34:0] recip_prod;
    logic [20:0] q_x90;
    logic [7:0]  rem;
    logic [13:0] q_fix;

    always_comb
    begin
        a_ext = {1'b0, req.angle} + (req.use_cos ? {1'b0, QUARTER_TURN} : 14'd0);
        a_w   = (a_ext >= {1'b0, FULL_TURN}) ? 13'(a_ext - {1'b0, FULL_TURN})
                                             : a_ext[ANG_W-1:0];
        if (a_w >= 13'd4320)
        begin
            quad = 2'd3;
            quad_base = 13'd4320;
        end
        else if (a_w >= 13'd2880)
        begin
            quad = 2'd2;
            quad_base = 13'd2880;
        end
        else if (a_w >= QUARTER_TURN)
        begin
            quad = 2'd1;
            quad_base = QUARTER_TURN;
        end
        else
        begin
            quad = 2'd0;
            quad_base = 13'd0;
        end
        r_in   = 11'(a_w - quad_base);
        r_fold = quad[0] ? 11'(11'd1440 - r_in) : r_in;
    end

    // stage 1: segment index as r/90 by reciprocal, exact over 0..1440
    assign idx_prod = 25'(r1_reg * 25'd11651);

    // stage 2: segment fraction and interpolation product
    always_comb
    begin
        idx_x90 = 11'(idx2_reg * 11'd90);
        frac    = 7'(r2_reg - idx_x90);
        nxt_idx = (idx2_reg == 5'd16) ? 5'd16 : 5'(idx2_reg + 5'd1);
        tab_lo  = quarter_sine(idx2_reg);
        tab_hi  = quarter_sine(nxt_idx);
        delta   = 13'(tab_hi - tab_lo);
    end

    // stage 3: divide product by 90 through reciprocal, low by at most one
    assign recip_prod = 35'(p3_reg * 35'd23301);

    // stage 4: one correction step
    always_comb
    begin
        q_x90 = 21'(q4_reg * 21'd90);
        rem   = 8'(21'({1'b0, p4_reg}) - q_x90);
        q_fix = (rem >= 8'd90) ? 14'(q4_reg + 14'd1) : q4_reg;
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], req.valid};
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        r1_reg    <= r_fold;
        neg1_reg  <= quad[1];
        r2_reg    <= r1_reg;
        idx2_reg  <= idx_prod[24:20];
        neg2_reg  <= neg1_reg;
        p3_reg    <= 20'(delta * frac);
        base3_reg <= tab_lo;
        neg3_reg  <= neg2_reg;
        q4_reg    <= recip_prod[34:21];
        p4_reg    <= p3_reg;
        base4_reg <= base3_reg;
        neg4_reg  <= neg3_reg;
        mag5_reg  <= 17'(base4_reg + {3'd0, q_fix});
        neg5_reg  <= neg4_reg;
    end

    assign res.valid = vld_reg[4];
    assign res.mag   = mag5_reg;
    assign res.neg   = neg5_reg;

endmodule

// ===== sv/grmd_div.sv =====
// grmd_div: restoring divider, one quotient bit per cycle
// depends on grmd_pkg
module grmd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [grmd_pkg::DIVD_W-1:0] dividend,
    input  logic [grmd_pkg::RATE_W-1:0] divisor,
    output logic                        busy,
    output logic                        done,
    output logic [grmd_pkg::DIVD_W-1:0] quotient
);
    import grmd_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] dvs_reg;
    logic [RATE_W:0]   trial;
    logic              ge;

    // shift in next dividend bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVD_W-1]};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= 6'(cnt_reg + 6'd1);
                if (cnt_reg == 6'(DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? RATE_W'(trial - {1'b0, dvs_reg}) : trial[RATE_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
